// ===== rtl/cbfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_pkg: shared types and constants of the bit-coded field decoder
// Holds the field type codes, the decoder phases, the decoder state record
// and the result record.
// ----------------------------------------------------------------------------
package cbfd_pkg;

  localparam logic [3:0] OP_B   = 4'd0;
  localparam logic [3:0] OP_BB  = 4'd1;
  localparam logic [3:0] OP_RC  = 4'd2;
  localparam logic [3:0] OP_RS  = 4'd3;
  localparam logic [3:0] OP_RL  = 4'd4;
  localparam logic [3:0] OP_RD  = 4'd5;
  localparam logic [3:0] OP_BS  = 4'd6;
  localparam logic [3:0] OP_BL  = 4'd7;
  localparam logic [3:0] OP_BD  = 4'd8;
  localparam logic [3:0] OP_MC  = 4'd9;
  localparam logic [3:0] OP_MCS = 4'd10;
  localparam logic [3:0] OP_MS  = 4'd11;
  localparam logic [3:0] OP_H   = 4'd12;
  localparam logic [3:0] OP_BT  = 4'd13;

  localparam logic [1:0] PFX_WORD = 2'd0;
  localparam logic [1:0] PFX_BYTE = 2'd1;
  localparam logic [1:0] PFX_ZERO = 2'd2;

  localparam logic [63:0] DOUBLE_ONE = 64'h3FF0_0000_0000_0000;
  localparam logic [63:0] SHORT_TOP  = 64'd256;

  typedef enum logic [2:0] {
    PH_PREFIX = 3'd0,
    PH_RAW    = 3'd1,
    PH_MC     = 3'd2,
    PH_MS     = 3'd3,
    PH_HDR    = 3'd4,
    PH_HBODY  = 3'd5,
    PH_FLAG   = 3'd6
  } phase_t;

  typedef struct packed {
    logic [3:0]  field_type;
    logic        busy;
    phase_t      phase;
    logic [4:0]  bit_in_unit;
    logic [15:0] unit_shift;
    logic [3:0]  unit_count;
    logic [63:0] accumulator;
    logic [1:0]  prefix_code;
    logic [3:0]  remaining_bytes;
    logic [3:0]  handle_code;
  } dec_state_t;

  typedef struct packed {
    logic        valid;
    logic [63:0] field_value;
    logic [3:0]  handle_code;
  } result_t;

endpackage : cbfd_pkg
`default_nettype wire

// ===== rtl/cbfd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_if: channel interfaces of the bit-coded field decoder
// One interface carries stream bits in, the other carries decoded fields out.
// ----------------------------------------------------------------------------
interface cbfd_bit_if;
  logic       valid;
  logic       ready;
  logic       stream_bit;
  logic [3:0] operation;

  modport source (output valid, output stream_bit, output operation, input ready);
  modport sink (input valid, input stream_bit, input operation, output ready);
endinterface : cbfd_bit_if

interface cbfd_field_if;
  logic        valid;
  logic        ready;
  logic [63:0] field_value;
  logic [3:0]  handle_code;

  modport source (output valid, output field_value, output handle_code, input ready);
  modport sink (input valid, input field_value, input handle_code, output ready);
endinterface : cbfd_field_if
`default_nettype wire

// ===== rtl/cbfd_decode.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_decode: field decoding state machine
// Holds the decoder state and advances it by one stream bit per firing,
// producing a result when a field completes.
// ----------------------------------------------------------------------------
module cbfd_decode
  import cbfd_pkg::*;
#(
  parameter int MAX_MC_BYTES = 8,
  parameter int MAX_MS_UNITS = 4
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic       stream_bit,
  input  wire logic [3:0] operation,
  output result_t         res
);

  localparam logic [4:0] MC_CAP = 5'(MAX_MC_BYTES);
  localparam logic [4:0] MS_CAP = 5'(MAX_MS_UNITS);

  dec_state_t st;
  dec_state_t st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    logic [15:0] u;
    logic [15:0] word;
    logic [6:0]  pay;
    logic [7:0]  sh;
    logic        last;
    logic        neg;
    logic        unit_done;
    st_next   = st;
    res       = '0;
    u         = '0;
    word      = '0;
    pay       = '0;
    sh        = '0;
    last      = 1'b0;
    neg       = 1'b0;
    unit_done = 1'b0;
    if (fire && (st.busy || operation <= OP_BT)) begin
      if (!st.busy) begin
        st_next = '0;
        st_next.field_type = operation;
        st_next.busy = 1'b1;
        case (operation)
          OP_RC: begin
            st_next.phase = PH_RAW;
            st_next.remaining_bytes = 4'd1;
          end
          OP_RS: begin
            st_next.phase = PH_RAW;
            st_next.remaining_bytes = 4'd2;
          end
          OP_RL: begin
            st_next.phase = PH_RAW;
            st_next.remaining_bytes = 4'd4;
          end
          OP_RD: begin
            st_next.phase = PH_RAW;
            st_next.remaining_bytes = 4'd8;
          end
          OP_MC, OP_MCS: st_next.phase = PH_MC;
          OP_MS:         st_next.phase = PH_MS;
          OP_H:          st_next.phase = PH_HDR;
          OP_BT:         st_next.phase = PH_FLAG;
          default:       st_next.phase = PH_PREFIX;
        endcase
      end

      case (st_next.phase)
        PH_FLAG: begin
          if (stream_bit) begin
            res.valid = 1'b1;
            st_next.busy = 1'b0;
          end else begin
            st_next.phase = PH_PREFIX;
          end
        end
        PH_PREFIX: begin
          st_next.prefix_code = {st_next.prefix_code[0], stream_bit};
          st_next.bit_in_unit = st_next.bit_in_unit + 5'd1;
          if (st_next.field_type == OP_B) begin
            res.valid = 1'b1;
            res.field_value = {63'd0, stream_bit};
            st_next.busy = 1'b0;
          end else if (st_next.bit_in_unit >= 5'd2) begin
            if (st_next.field_type == OP_BB) begin
              res.valid = 1'b1;
              res.field_value = {62'd0, st_next.prefix_code};
              st_next.busy = 1'b0;
            end else if (st_next.prefix_code == PFX_WORD ||
                         (st_next.prefix_code == PFX_BYTE &&
                          (st_next.field_type == OP_BS || st_next.field_type == OP_BL))) begin
              st_next.phase = PH_RAW;
              st_next.unit_count = '0;
              st_next.accumulator = '0;
              st_next.bit_in_unit = '0;
              st_next.unit_shift = '0;
              if (st_next.prefix_code == PFX_BYTE) begin
                st_next.remaining_bytes = 4'd1;
              end else if (st_next.field_type == OP_BS) begin
                st_next.remaining_bytes = 4'd2;
              end else if (st_next.field_type == OP_BL) begin
                st_next.remaining_bytes = 4'd4;
              end else begin
                st_next.remaining_bytes = 4'd8;
              end
            end else begin
              res.valid = 1'b1;
              st_next.busy = 1'b0;
              if (st_next.field_type == OP_BS) begin
                res.field_value = (st_next.prefix_code == PFX_ZERO) ? 64'd0 : SHORT_TOP;
              end else if (st_next.field_type != OP_BL &&
                           st_next.prefix_code == PFX_BYTE) begin
                res.field_value = DOUBLE_ONE;
              end
            end
          end
        end
        default: begin
          st_next.unit_shift = {st_next.unit_shift[14:0], stream_bit};
          st_next.bit_in_unit = st_next.bit_in_unit + 5'd1;
          unit_done = (st_next.phase == PH_MS) ? (st_next.bit_in_unit == 5'd16)
                                               : (st_next.bit_in_unit == 5'd8);
          if (unit_done) begin
            u = st_next.unit_shift;
            st_next.bit_in_unit = '0;
            st_next.unit_shift = '0;
            case (st_next.phase)
              PH_RAW: begin
                st_next.accumulator = st_next.accumulator |
                  ({56'd0, u[7:0]} << {st_next.unit_count[2:0], 3'b000});
                st_next.unit_count = st_next.unit_count + 4'd1;
                st_next.remaining_bytes = st_next.remaining_bytes - 4'd1;
                if (st_next.remaining_bytes == 4'd0) begin
                  res.valid = 1'b1;
                  res.field_value = st_next.accumulator;
                  st_next.busy = 1'b0;
                end
              end
              PH_MC: begin
                pay = u[6:0];
                last = !u[7] || ({1'b0, st_next.unit_count} + 5'd1 >= MC_CAP);
                sh = {1'b0, st_next.unit_count, 3'b000} - {4'd0, st_next.unit_count};
                if (last && st_next.field_type == OP_MCS && u[6]) begin
                  neg = 1'b1;
                  pay[6] = 1'b0;
                end
                if (sh < 8'd64) begin
                  st_next.accumulator = st_next.accumulator | ({57'd0, pay} << sh[5:0]);
                end
                if (last) begin
                  res.valid = 1'b1;
                  res.field_value = neg ? (64'd0 - st_next.accumulator)
                                        : st_next.accumulator;
                  st_next.busy = 1'b0;
                end else begin
                  st_next.unit_count = st_next.unit_count + 4'd1;
                end
              end
              PH_MS: begin
                word = {u[7:0], u[15:8]};
                sh = {st_next.unit_count, 4'b0000} - {4'd0, st_next.unit_count};
                last = !word[15] || ({1'b0, st_next.unit_count} + 5'd1 >= MS_CAP);
                if (sh < 8'd64) begin
                  st_next.accumulator = st_next.accumulator |
                    ({49'd0, word[14:0]} << sh[5:0]);
                end
                if (last) begin
                  res.valid = 1'b1;
                  res.field_value = st_next.accumulator;
                  st_next.busy = 1'b0;
                end else begin
                  st_next.unit_count = st_next.unit_count + 4'd1;
                end
              end
              PH_HDR: begin
                st_next.handle_code = u[7:4];
                st_next.remaining_bytes = u[3:0];
                st_next.accumulator = '0;
                if (u[3:0] == 4'd0) begin
                  res.valid = 1'b1;
                  res.handle_code = u[7:4];
                  st_next.busy = 1'b0;
                end else begin
                  st_next.phase = PH_HBODY;
                end
              end
              default: begin
                st_next.accumulator = {st_next.accumulator[55:0], u[7:0]};
                st_next.remaining_bytes = st_next.remaining_bytes - 4'd1;
                if (st_next.remaining_bytes == 4'd0) begin
                  res.valid = 1'b1;
                  res.field_value = st_next.accumulator;
                  res.handle_code = st_next.handle_code;
                  st_next.busy = 1'b0;
                end
              end
            endcase
          end
        end
      endcase
    end
  end

endmodule : cbfd_decode
`default_nettype wire

// ===== rtl/cbfd_out_buf.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_out_buf: two-entry result buffer
// Registers decoded fields and decouples the decoder from output stalls.
// ----------------------------------------------------------------------------
module cbfd_out_buf
  import cbfd_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  result_t      res,
  output logic         space,
  cbfd_field_if.source fields
);

  logic [67:0] entry [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;
  logic        pop;

  assign space  = (count != 2'd2);
  assign push   = res.valid && space;
  assign pop    = fields.valid && fields.ready;

  assign fields.valid       = (count != 2'd0);
  assign fields.field_value = entry[rd_ptr][67:4];
  assign fields.handle_code = entry[rd_ptr][3:0];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= {res.field_value, res.handle_code};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule : cbfd_out_buf
`default_nettype wire

// ===== rtl/cad_bitcoded_field_decoder_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cad_bitcoded_field_decoder_unit: bit-coded variable-length field decoder
// Decodes a serial stream, one bit per item, into typed field values.
//
//   Channel  Direction  Payload
//   bits     in         stream_bit, operation
//   fields   out        field_value, handle_code
//
// Each stream bit passes an input register, one step of the decoder logic and
// a two-entry result buffer, so one bit is taken every cycle while the buffer
// has space; the bit that completes a field writes its result into the buffer.
// Reset is synchronous and leaves the decoder idle with both stages empty.
// An output stall fills the result buffer; after that the input register
// holds its bit and bits.ready drops until a result is taken.
// ----------------------------------------------------------------------------
module cad_bitcoded_field_decoder_unit
  import cbfd_pkg::*;
#(
  parameter int MAX_MC_BYTES = 8,
  parameter int MAX_MS_UNITS = 4
) (
  input  wire logic    clk,
  input  wire logic    rst,
  cbfd_bit_if.sink     bits,
  cbfd_field_if.source fields
);

  logic       in_valid;
  logic       in_bit;
  logic [3:0] in_op;
  logic       space;
  logic       fire;
  result_t    res;

  assign fire       = in_valid && space;
  assign bits.ready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (bits.ready) begin
      in_valid <= bits.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (bits.ready && bits.valid) begin
      in_bit <= bits.stream_bit;
      in_op  <= bits.operation;
    end
  end

  cbfd_decode #(
    .MAX_MC_BYTES(MAX_MC_BYTES),
    .MAX_MS_UNITS(MAX_MS_UNITS)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .stream_bit(in_bit),
    .operation (in_op),
    .res       (res)
  );

  cbfd_out_buf u_out_buf (
    .clk   (clk),
    .rst   (rst),
    .res   (res),
    .space (space),
    .fields(fields)
  );

endmodule : cad_bitcoded_field_decoder_unit
`default_nettype wire

// ===== bench/cbfd_decode_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cbfd_decode_checker: field predictor and scoreboard for the bit decoder
// Watches both channels of the decoder. Every accepted stream bit steps a
// local copy of the decoder; each field it completes becomes an expected
// result, and every result taken from the block is compared with the oldest.
// ----------------------------------------------------------------------------
module cbfd_decode_checker
  import cbfd_pkg::*;
#(
  parameter int MAX_MC_BYTES = 8,
  parameter int MAX_MS_UNITS = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  cbfd_bit_if       bits,
  cbfd_field_if     fields,
  output int        errors,
  output int        pending,
  output int        fields_seen
);

  typedef struct packed {
    logic [63:0] value;
    logic [3:0]  code;
  } field_t;

  field_t expected_fields[$];
  field_t want;
  int mismatches = 0;
  int fields_taken = 0;

  logic [3:0]  ftype;
  logic        busy;
  phase_t      ph;
  logic [4:0]  biu;
  logic [15:0] ushift;
  logic [3:0]  ucount;
  logic [63:0] acc;
  logic [1:0]  pfx;
  logic [3:0]  remain;
  logic [3:0]  hcode;

  logic        got;
  logic [63:0] got_value;
  logic [3:0]  got_code;

  task automatic clear_state();
    ph = PH_PREFIX;
    biu = '0;
    ushift = '0;
    ucount = '0;
    acc = '0;
    pfx = '0;
    remain = '0;
    hcode = '0;
  endtask

  task automatic open_bytes(input int n);
    ph = PH_RAW;
    remain = 4'(n);
    ucount = '0;
    acc = '0;
    biu = '0;
    ushift = '0;
  endtask

  task automatic decode_bit(input logic b, input logic [3:0] op, output logic done,
                            output logic [63:0] val, output logic [3:0] code);
    logic [15:0] u;
    logic [15:0] word;
    logic [3:0]  idx;
    logic [6:0]  pay;
    logic        last;
    logic        neg;
    int          sh;
    int          width;
    done = 1'b0;
    val = '0;
    code = '0;
    if (busy || op <= OP_BT) begin
      if (!busy) begin
        clear_state();
        ftype = op;
        busy = 1'b1;
        case (op)
          OP_RC: open_bytes(1);
          OP_RS: open_bytes(2);
          OP_RL: open_bytes(4);
          OP_RD: open_bytes(8);
          OP_MC, OP_MCS: ph = PH_MC;
          OP_MS: ph = PH_MS;
          OP_H: ph = PH_HDR;
          OP_BT: ph = PH_FLAG;
          default: ;
        endcase
      end
      if (ph == PH_FLAG) begin
        if (b) begin
          done = 1'b1;
        end else begin
          ph = PH_PREFIX;
        end
      end else if (ph == PH_PREFIX) begin
        pfx = {pfx[0], b};
        biu = biu + 5'd1;
        if (ftype == OP_B) begin
          done = 1'b1;
          val = 64'(b);
        end else if (biu >= 5'd2) begin
          case (ftype)
            OP_BB: begin
              done = 1'b1;
              val = 64'(pfx);
            end
            OP_BS: begin
              if (pfx == PFX_WORD) open_bytes(2);
              else if (pfx == PFX_BYTE) open_bytes(1);
              else begin
                done = 1'b1;
                val = (pfx == PFX_ZERO) ? '0 : SHORT_TOP;
              end
            end
            OP_BL: begin
              if (pfx == PFX_WORD) open_bytes(4);
              else if (pfx == PFX_BYTE) open_bytes(1);
              else done = 1'b1;
            end
            default: begin
              if (pfx == PFX_WORD) open_bytes(8);
              else begin
                done = 1'b1;
                val = (pfx == PFX_BYTE) ? DOUBLE_ONE : '0;
              end
            end
          endcase
        end
      end else begin
        width = (ph == PH_MS) ? 16 : 8;
        ushift = {ushift[14:0], b};
        biu = biu + 5'd1;
        if (int'(biu) == width) begin
          u = ushift;
          biu = '0;
          ushift = '0;
          idx = ucount;
          case (ph)
            PH_RAW: begin
              acc |= 64'(u[7:0]) << (8 * ucount[2:0]);
              ucount = ucount + 4'd1;
              remain = remain - 4'd1;
              if (remain == 4'd0) begin
                done = 1'b1;
                val = acc;
              end
            end
            PH_MC: begin
              pay = u[6:0];
              last = !u[7] || (int'(idx) + 1 >= MAX_MC_BYTES);
              neg = last && ftype == OP_MCS && u[6];
              if (neg) pay[6] = 1'b0;
              sh = 7 * int'(idx);
              if (sh < 64) acc |= 64'(pay) << sh;
              if (last) begin
                done = 1'b1;
                val = neg ? 64'd0 - acc : acc;
              end else begin
                ucount = idx + 4'd1;
              end
            end
            PH_MS: begin
              word = {u[7:0], u[15:8]};
              last = !word[15] || (int'(idx) + 1 >= MAX_MS_UNITS);
              sh = 15 * int'(idx);
              if (sh < 64) acc |= 64'(word[14:0]) << sh;
              if (last) begin
                done = 1'b1;
                val = acc;
              end else begin
                ucount = idx + 4'd1;
              end
            end
            PH_HDR: begin
              hcode = u[7:4];
              remain = u[3:0];
              acc = '0;
              if (remain == 4'd0) begin
                done = 1'b1;
                code = hcode;
              end else begin
                ph = PH_HBODY;
              end
            end
            default: begin
              acc = {acc[55:0], u[7:0]};
              remain = remain - 4'd1;
              if (remain == 4'd0) begin
                done = 1'b1;
                val = acc;
                code = hcode;
              end
            end
          endcase
        end
      end
      if (done) busy = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_state();
      ftype = '0;
      busy = 1'b0;
      expected_fields.delete();
    end else begin
      if (fields.valid && fields.ready) begin
        fields_taken++;
        if (expected_fields.size() == 0) begin
          mismatches++;
          $error("Unexpected field: field_value %h, handle_code %h",
                 fields.field_value, fields.handle_code);
        end else begin
          want = expected_fields.pop_front();
          if (fields.field_value !== want.value) begin
            mismatches++;
            $error("field_value: expected %h, got %h", want.value, fields.field_value);
          end
          if (fields.handle_code !== want.code) begin
            mismatches++;
            $error("handle_code: expected %h, got %h", want.code, fields.handle_code);
          end
        end
      end
      if (bits.valid && bits.ready) begin
        decode_bit(bits.stream_bit, bits.operation, got, got_value, got_code);
        if (got) expected_fields.push_back('{value: got_value, code: got_code});
      end
    end
    errors <= mismatches;
    pending <= expected_fields.size();
    fields_seen <= fields_taken;
  end

endmodule : cbfd_decode_checker
`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench: stream stimulus and verdict for the bit-coded field decoder
// Sends a directed set of fields covering every type, prefix form, unit cap
// and the unknown types, then random well-formed fields mixed with noise,
// with random gaps and output stalls. The checker does all comparisons.
// ----------------------------------------------------------------------------
module testbench;
  import cbfd_pkg::*;

  localparam int MC_CAP      = 8;
  localparam int MS_CAP      = 4;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbfd_bit_if   bits_ch ();
  cbfd_field_if fields_ch ();

  int errors;
  int pending;
  int fields_seen;
  int stream_bits = 0;
  int fields_sent = 0;
  int cycle_count = 0;

  logic       in_quiet = 1'b0;
  logic       out_quiet = 1'b0;
  logic [3:0] lead_op = '0;
  logic       lead_pending = 1'b0;

  cad_bitcoded_field_decoder_unit #(
    .MAX_MC_BYTES(MC_CAP),
    .MAX_MS_UNITS(MS_CAP)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .bits(bits_ch),
    .fields(fields_ch)
  );

  cbfd_decode_checker #(
    .MAX_MC_BYTES(MC_CAP),
    .MAX_MS_UNITS(MS_CAP)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .bits(bits_ch),
    .fields(fields_ch),
    .errors(errors),
    .pending(pending),
    .fields_seen(fields_seen)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // The type code goes out only on the first bit of a field; every later bit
  // carries a random code, which the decoder must ignore.
  task automatic push_bit(input logic b);
    int gap;
    logic [3:0] op;
    gap = in_quiet ? 0 : $urandom_range(0, 17);
    op = lead_pending ? lead_op : 4'($urandom_range(0, 15));
    lead_pending = 1'b0;
    if (gap > 0) begin
      bits_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    bits_ch.valid <= 1'b1;
    bits_ch.stream_bit <= b;
    bits_ch.operation <= op;
    do @(posedge clk); while (!bits_ch.ready);
    stream_bits++;
  endtask

  task automatic push_byte(input logic [7:0] v);
    for (int i = 7; i >= 0; i--) push_bit(v[i]);
  endtask

  function automatic logic [7:0] pick_byte(input int fill);
    case (fill)
      1: return 8'hFF;
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // sel picks the field bits, the prefix code, the unit count or the handle
  // length; fill picks random, all-ones or all-zero bytes.
  task automatic send_field(input logic [3:0] op, input int sel, input int fill);
    int n;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [1:0] pfx;
    n = 0;
    lead_op = op;
    lead_pending = 1'b1;
    case (op)
      OP_B: push_bit(sel[0]);
      OP_BB: begin
        push_bit(sel[1]);
        push_bit(sel[0]);
      end
      OP_RC: n = 1;
      OP_RS: n = 2;
      OP_RL: n = 4;
      OP_RD: n = 8;
      OP_BS, OP_BL, OP_BD, OP_BT: begin
        if (op == OP_BT) push_bit(sel == 4);
        if (op != OP_BT || sel != 4) begin
          pfx = 2'(sel);
          push_bit(pfx[1]);
          push_bit(pfx[0]);
          if (pfx == PFX_WORD) n = (op == OP_BS) ? 2 : (op == OP_BL) ? 4 : 8;
          else if (pfx == PFX_BYTE && (op == OP_BS || op == OP_BL)) n = 1;
        end
      end
      OP_MC, OP_MCS: begin
        for (int i = 0; i < sel; i++) begin
          lo = pick_byte(fill);
          if (i < sel - 1) lo[7] = 1'b1;
          else if (sel < MC_CAP) lo[7] = 1'b0;
          push_byte(lo);
        end
      end
      OP_MS: begin
        for (int i = 0; i < sel; i++) begin
          lo = pick_byte(fill);
          hi = pick_byte(fill);
          if (i < sel - 1) hi[7] = 1'b1;
          else if (sel < MS_CAP) hi[7] = 1'b0;
          push_byte(lo);
          push_byte(hi);
        end
      end
      OP_H: begin
        lo = pick_byte(fill);
        push_byte({lo[7:4], 4'(sel)});
        n = sel;
      end
      default: push_bit(1'($urandom_range(0, 1)));
    endcase
    for (int i = 0; i < n; i++) push_byte(pick_byte(fill));
    if (op <= OP_BT) fields_sent++;
  endtask

  task automatic drain_wait();
    bits_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int stall;
    fields_ch.ready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      stall = out_quiet ? 0 : $urandom_range(0, 17);
      if (stall > 0) begin
        fields_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      fields_ch.ready <= 1'b1;
      do @(posedge clk); while (!fields_ch.valid);
      if ($urandom_range(0, 5) == 0) out_quiet = !out_quiet;
    end
  end

  initial begin
    int r;
    int sel;
    int fill;
    logic [3:0] op;
    bits_ch.valid = 1'b0;
    bits_ch.stream_bit = 1'b0;
    bits_ch.operation = OP_B;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_field(OP_B, 0, 0);
    send_field(OP_B, 1, 0);
    send_field(OP_BB, 3, 0);
    send_field(OP_RC, 0, 1);
    send_field(OP_RS, 0, 2);
    send_field(OP_RL, 0, 0);
    send_field(OP_RD, 0, 1);
    for (int p = 0; p < 4; p++) send_field(OP_BS, p, 1);
    send_field(OP_BL, 0, 1);
    send_field(OP_BL, 1, 0);
    send_field(OP_BL, 2, 0);
    send_field(OP_BD, 0, 1);
    send_field(OP_BD, 1, 0);
    send_field(OP_BD, 3, 0);
    send_field(OP_MC, 1, 2);
    send_field(OP_MC, MC_CAP, 1);
    send_field(OP_MCS, 1, 1);
    send_field(OP_MCS, MC_CAP, 0);
    send_field(OP_MS, 1, 0);
    send_field(OP_MS, MS_CAP, 1);
    send_field(OP_H, 0, 1);
    send_field(OP_H, 15, 1);
    send_field(OP_BT, 4, 0);
    send_field(OP_BT, 1, 0);
    send_field(OP_BT, 0, 0);
    send_field(4'd14, 0, 0);
    send_field(4'd15, 0, 0);
    drain_wait();

    while (stream_bits < 950) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) in_quiet = !in_quiet;
      if (r < 4) drain_wait();
      if (r >= 90) begin
        lead_pending = 1'b0;
        repeat ($urandom_range(1, 12)) push_bit(1'($urandom_range(0, 1)));
      end else begin
        op = 4'($urandom_range(0, 13));
        case (op)
          OP_MC, OP_MCS: sel = $urandom_range(1, MC_CAP);
          OP_MS: sel = $urandom_range(1, MS_CAP);
          OP_H: sel = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
                                                  : $urandom_range(0, 4);
          OP_BT: sel = $urandom_range(0, 4);
          default: sel = $urandom_range(0, 3);
        endcase
        fill = ($urandom_range(0, 9) < 8) ? 0 : $urandom_range(1, 2);
        send_field(op, sel, fill);
      end
    end

    bits_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    $display("Run covered %0d stream bits, %0d fields sent and %0d decoded fields,",
             stream_bits, fields_sent, fields_seen);
    $display("over every field type, prefix form, unit cap, unknown types, noise,");
    $display("input gaps and output stalls.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule : testbench
`default_nettype wire
